// File: hdl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rrfr_pkg.sv
// Package for the reader reply frame receiver: codes, constants and shared types.
// No dependencies.
`default_nettype none

package rrfr_pkg;

    localparam logic [7:0]  HDR0         = 8'hAA;
    localparam logic [7:0]  HDR1         = 8'hBB;
    localparam logic [7:0]  CMD_RESET    = 8'h41;
    localparam logic [31:0] TYPE_NEW_ID  = 32'h0001_4115;
    localparam logic [15:0] TYPE_OLD_ID  = 16'h4115;
    localparam logic [7:0]  PLEN_NEW     = 8'd4;
    localparam logic [7:0]  PLEN_OLD     = 8'd2;
    localparam logic [7:0]  PLEN_CARD    = 8'd5;

    // width for count/length compares, covers len + 3 for any 8-bit length
    localparam int CMP_W         = 10;
    localparam int PAYLOAD_SLOTS = 5;

    typedef enum logic [1:0] {
        EV_NEW_MODULE = 2'd0,
        EV_OLD_MODULE = 2'd1,
        EV_CARD_READ  = 2'd2,
        EV_OTHER      = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        MOD_UNKNOWN = 2'd0,
        MOD_NEW     = 2'd1,
        MOD_OLD     = 2'd2
    } module_kind_t;

    typedef logic [PAYLOAD_SLOTS-1:0][7:0] payload_t;

    typedef struct packed {
        logic       clear;
        logic       step;
        logic       cap_en;
        logic [2:0] cap_slot;
    } scan_ctrl_t;

    typedef struct packed {
        logic       pair_hit;
        logic       data_aa;
        logic [7:0] xor_now;
    } scan_stat_t;

endpackage

`default_nettype wire

// File: hdl/rrfr_frame_buf.sv
// Frame byte store: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module rrfr_frame_buf #(
    parameter int FRAME_MAX = 32,
    localparam int ADDR_W   = $clog2(FRAME_MAX)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [FRAME_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/rrfr_scan_unit.sv
// Shared scan unit: header pair search, running XOR and payload capture.
// Depends on rrfr_pkg.
`default_nettype none

module rrfr_scan_unit
    import rrfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire scan_ctrl_t ctrl,
    input  wire logic [7:0] rd_data,
    output scan_stat_t      stat,
    output payload_t        payload
);

    logic [7:0] acc_reg;
    logic       prev_aa_reg;
    payload_t   payload_reg;

    assign stat.data_aa  = (rd_data == HDR0);
    assign stat.pair_hit = prev_aa_reg && (rd_data == HDR1);
    assign stat.xor_now  = acc_reg ^ rd_data;
    assign payload       = payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            prev_aa_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            acc_reg     <= '0;
            prev_aa_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            acc_reg     <= stat.xor_now;
            prev_aa_reg <= stat.data_aa;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_en)
        begin
            payload_reg[ctrl.cap_slot] <= rd_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rrfr_classify.sv
// Frame classifier: module type detection and card id tracking.
// Depends on rrfr_pkg.
`default_nettype none

module rrfr_classify
    import rrfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       upd,
    input  wire payload_t   payload,
    input  wire logic [7:0] plen,
    input  wire logic [7:0] card_cmd,
    output event_kind_t     ev_kind,
    output module_kind_t    module_kind,
    output logic [31:0]     card_id,
    output logic [31:0]     previous_card_id
);

    event_kind_t  kind_reg, kind_next;
    module_kind_t mod_reg, mod_next;
    logic [31:0]  card_reg, card_next;
    logic [31:0]  prev_reg, prev_next;

    always_comb
    begin
        kind_next = EV_OTHER;
        mod_next  = mod_reg;
        card_next = card_reg;
        prev_next = prev_reg;
        if (mod_reg == MOD_UNKNOWN)
        begin
            if (plen == PLEN_NEW &&
                {payload[0], payload[1], payload[2], payload[3]} == TYPE_NEW_ID)
            begin
                kind_next = EV_NEW_MODULE;
                mod_next  = MOD_NEW;
            end
            else if (plen == PLEN_OLD && {payload[0], payload[1]} == TYPE_OLD_ID)
            begin
                kind_next = EV_OLD_MODULE;
                mod_next  = MOD_OLD;
            end
        end
        else if (plen == PLEN_CARD && payload[0] == card_cmd)
        begin
            kind_next = EV_CARD_READ;
            prev_next = card_reg;
            card_next = {payload[1], payload[2], payload[3], payload[4]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= EV_NEW_MODULE;
            mod_reg  <= MOD_UNKNOWN;
            card_reg <= '0;
            prev_reg <= '0;
        end
        else if (upd)
        begin
            kind_reg <= kind_next;
            mod_reg  <= mod_next;
            card_reg <= card_next;
            prev_reg <= prev_next;
        end
    end

    assign ev_kind          = kind_reg;
    assign module_kind      = mod_reg;
    assign card_id          = card_reg;
    assign previous_card_id = prev_reg;

endmodule

`default_nettype wire

// File: hdl/rfid_reply_frame_receiver.sv
// Reader reply frame receiver, top level: sequencer over the byte store and scan unit.
// Depends on rrfr_pkg, rrfr_frame_buf, rrfr_scan_unit, rrfr_classify, assert_macros.svh.
//
// Usage:
//   s_axis carries one received byte per transfer. m_axis carries one event per valid
//   frame (AA BB L payload check). cfg_wr_en/cfg_wr_data set the card reply command.
//   Ordinary bytes are taken back to back; s_axis_tready stays high between them.
//   After the length byte the block holds s_axis_tready low in S_SETTLE to check it.
//   A check byte starts a pass over the store through the single read port (S_SUM);
//   S_EMIT then posts the event into the output register that drives m_axis_tvalid.
//   A bad length or check starts a resync: the kept bytes are read in turn (S_SCAN)
//   for a later AA BB pair, then the bytes from that pair on are moved to the front
//   (S_SHIFT), repeated while the moved bytes are still not a proper frame start.
//   Each repeat drops at least two bytes.
//   The event sits in an output register; new bytes are still taken while it waits.
//   If a second frame completes before the first event is taken, the block holds
//   in its post state with tready low until m_axis_tready frees the register.
//   Reset (rst_n low, asynchronous) empties the frame, clears the module type and
//   both card ids, and restores the command to 0x41. The byte store needs no clear.
`default_nettype none
`include "assert_macros.svh"

module rfid_reply_frame_receiver
    import rrfr_pkg::*;
#(
    parameter int FRAME_MAX = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] event_kind, [33:2] card_id, [65:34] previous_card_id,
    // [67:66] module_type, [75:68] payload_length, [79:76] zero
    output logic [79:0]      m_axis_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    localparam int ADDR_W = $clog2(FRAME_MAX);
    localparam int CNT_W  = $clog2(FRAME_MAX + 1);
    localparam logic [CMP_W-1:0] FRAME_MAX_X = CMP_W'(FRAME_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETTLE,
        S_SCAN,
        S_SHIFT,
        S_SUM,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        chk_reg, chk_next;
    logic [CNT_W-1:0]  rptr_reg, rptr_next;
    logic [ADDR_W-1:0] dpos_reg, dpos_next;
    logic              dv_reg, dv_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [7:0]        plen_out_reg, plen_out_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        cmd_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;
    scan_ctrl_t        sctrl;
    scan_stat_t        sstat;
    payload_t          payload;
    logic              upd;
    event_kind_t       ev_kind;
    module_kind_t      mod_kind;
    logic [31:0]       card_id;
    logic [31:0]       prev_card_id;

    logic [CMP_W-1:0]  count_x, len_x, dpos_x, rptr_x, cap_off;
    logic [ADDR_W-1:0] shift_dst;
    logic              len_ok, prefix_ok, slot_free, issue;

    assign count_x   = CMP_W'(count_reg);
    assign len_x     = CMP_W'(len_reg);
    assign dpos_x    = CMP_W'(dpos_reg);
    assign rptr_x    = CMP_W'(rptr_reg);
    assign cap_off   = dpos_x - CMP_W'(3);
    assign shift_dst = dpos_reg - off_reg;
    assign len_ok    = (len_reg != 8'd0) && (len_x + CMP_W'(3) <= FRAME_MAX_X);
    assign prefix_ok = len_ok && (count_x <= len_x + CMP_W'(2));
    assign slot_free = !m_valid_reg || m_axis_tready;

    rrfr_frame_buf #(
        .FRAME_MAX (FRAME_MAX)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rptr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    rrfr_scan_unit u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sctrl),
        .rd_data (rd_data),
        .stat    (sstat),
        .payload (payload)
    );

    rrfr_classify u_cls (
        .clk              (clk),
        .rst_n            (rst_n),
        .upd              (upd),
        .payload          (payload),
        .plen             (len_reg - 8'd1),
        .card_cmd         (cmd_reg),
        .ev_kind          (ev_kind),
        .module_kind      (mod_kind),
        .card_id          (card_id),
        .previous_card_id (prev_card_id)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        chk_next      = chk_reg;
        rptr_next     = rptr_reg;
        dpos_next     = rptr_reg[ADDR_W-1:0];
        dv_next       = 1'b0;
        off_next      = off_reg;
        plen_out_next = plen_out_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = s_axis_tdata;
        sctrl         = '0;
        upd           = 1'b0;
        issue         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (count_reg == CNT_W'(0))
                    begin
                        if (s_axis_tdata == HDR0)
                        begin
                            wr_en      = 1'b1;
                            count_next = CNT_W'(1);
                        end
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        wr_en = 1'b1;
                        if (s_axis_tdata == HDR1)
                        begin
                            count_next = CNT_W'(2);
                        end
                        else if (s_axis_tdata == HDR0)
                        begin
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            count_next = CNT_W'(0);
                        end
                    end
                    else if (count_reg == CNT_W'(2))
                    begin
                        wr_en      = 1'b1;
                        len_next   = s_axis_tdata;
                        count_next = CNT_W'(3);
                        state_next = S_SETTLE;
                    end
                    else if (!prefix_ok)
                    begin
                        count_next = CNT_W'(0);
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (count_x == len_x + CMP_W'(2))
                        begin
                            chk_next    = s_axis_tdata;
                            rptr_next   = CNT_W'(2);
                            sctrl.clear = 1'b1;
                            state_next  = S_SUM;
                        end
                    end
                end
            end

            S_SETTLE:
            begin
                if (count_x < CMP_W'(3) || prefix_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rptr_next   = CNT_W'(1);
                    sctrl.clear = 1'b1;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                issue = (rptr_x < count_x);
                if (issue)
                begin
                    rptr_next = rptr_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                end
                if (dv_reg)
                begin
                    sctrl.step = 1'b1;
                    if (sstat.pair_hit)
                    begin
                        dv_next = 1'b0;
                        if (dpos_x + CMP_W'(1) == count_x)
                        begin
                            // pair is the last two bytes: nothing to move
                            count_next = count_reg - CNT_W'(dpos_reg - ADDR_W'(1));
                            state_next = S_SETTLE;
                        end
                        else
                        begin
                            off_next   = dpos_reg - ADDR_W'(1);
                            rptr_next  = CNT_W'(dpos_reg) + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    else if (dpos_x + CMP_W'(1) == count_x)
                    begin
                        dv_next    = 1'b0;
                        count_next = sstat.data_aa ? CNT_W'(1) : CNT_W'(0);
                        state_next = S_IDLE;
                    end
                end
            end

            S_SHIFT:
            begin
                issue = (rptr_x < count_x);
                if (issue)
                begin
                    rptr_next = rptr_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                end
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = shift_dst;
                    wr_data = rd_data;
                    if (shift_dst == ADDR_W'(2))
                    begin
                        len_next = rd_data;
                    end
                    if (dpos_x + CMP_W'(1) == count_x)
                    begin
                        dv_next    = 1'b0;
                        count_next = count_reg - CNT_W'(off_reg);
                        state_next = S_SETTLE;
                    end
                end
            end

            S_SUM:
            begin
                issue = (rptr_x + CMP_W'(1) < count_x);
                if (issue)
                begin
                    rptr_next = rptr_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                end
                if (dv_reg)
                begin
                    sctrl.step     = 1'b1;
                    sctrl.cap_en   = (dpos_x >= CMP_W'(3)) && (dpos_x <= CMP_W'(7));
                    sctrl.cap_slot = cap_off[2:0];
                    if (dpos_x + CMP_W'(2) == count_x)
                    begin
                        dv_next    = 1'b0;
                        state_next = (sstat.xor_now == chk_reg) ? S_EMIT : S_SETTLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    upd           = 1'b1;
                    plen_out_next = len_reg - 8'd1;
                    m_valid_next  = 1'b1;
                    count_next    = CNT_W'(0);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            len_reg      <= '0;
            chk_reg      <= '0;
            rptr_reg     <= '0;
            dpos_reg     <= '0;
            dv_reg       <= 1'b0;
            off_reg      <= '0;
            plen_out_reg <= '0;
            m_valid_reg  <= 1'b0;
            cmd_reg      <= CMD_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            chk_reg      <= chk_next;
            rptr_reg     <= rptr_next;
            dpos_reg     <= dpos_next;
            dv_reg       <= dv_next;
            off_reg      <= off_next;
            plen_out_reg <= plen_out_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en)
            begin
                cmd_reg <= cfg_wr_data;
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, plen_out_reg, mod_kind, prev_card_id, card_id, ev_kind};

    `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_x <= FRAME_MAX_X,
        "kept byte count overflow")
    `ASSERT_IMPLIES(a_idle_prefix, clk, rst_n,
        (state_reg == S_IDLE) && (count_x >= CMP_W'(3)), prefix_ok,
        "kept bytes not a proper frame start")
    `ASSERT_IMPLIES(a_sum_full, clk, rst_n, state_reg == S_SUM,
        count_x == len_x + CMP_W'(3), "check pass on incomplete frame")
    `ASSERT_NEXT(a_emit_post, clk, rst_n, (state_reg == S_EMIT) && slot_free,
        m_axis_tvalid && (state_reg == S_IDLE) && (count_reg == '0),
        "event not posted after valid frame")

endmodule

`default_nettype wire

// File: tb/tb_rfid_reply_frame_receiver.sv
`timescale 1ns / 1ps
// Testbench for rfid_reply_frame_receiver: byte stream in, one event per valid frame out.
// Checks every event against an in-bench frame parser; depends on rrfr_pkg and the RTL.
// Covers headers, lengths, checks, resyncs, type detection and card reads under idling.

module tb_rfid_reply_frame_receiver;
    import rrfr_pkg::*;

    localparam int FRAME_MAX = 32;
    localparam int DRAIN     = 2500;

    typedef struct packed {
        event_kind_t  kind;
        logic [31:0]  card;
        logic [31:0]  prev_card;
        module_kind_t mtype;
        logic [7:0]   plen;
    } frame_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;

    rfid_reply_frame_receiver #(.FRAME_MAX(FRAME_MAX)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [7:0]   pending_bytes [$];
    frame_event_t expected_events [$];
    logic [7:0]   body_bytes [0:28];
    int           src_idle = 17;
    int           snk_idle = 54;
    int           bytes_queued = 0;
    int           bytes_sent = 0;
    int           events_seen = 0;
    int           error_count = 0;
    int           settings_used = 1;

    // parser state
    logic [7:0]   kept [0:FRAME_MAX-1];
    int           kept_count = 0;
    module_kind_t found_kind = MOD_UNKNOWN;
    logic [31:0]  card_now = 32'h0;
    logic [31:0]  card_before = 32'h0;
    logic [7:0]   reply_cmd = CMD_RESET;

    function automatic bit length_fits(int len);
        return len != 0 && len + 3 <= FRAME_MAX;
    endfunction

    // look for a later AA BB in the kept bytes and move it to the front, else keep only a trailing AA
    function automatic int realign(int n);
        int i;
        int j;
        for (i = 1; i + 1 < n; i++)
        begin
            if (kept[i] == HDR0 && kept[i+1] == HDR1)
            begin
                for (j = 0; j < n - i; j++)
                    kept[j] = kept[j+i];
                return n - i;
            end
        end
        if (n >= 1 && kept[n-1] == HDR0)
        begin
            kept[0] = HDR0;
            return 1;
        end
        return 0;
    endfunction

    function automatic int drop_stale(int n);
        int  len;
        bit  done;
        done = 1'b0;
        while (n >= 3 && !done)
        begin
            len = kept[2];
            if (length_fits(len) && n <= len + 2)
                done = 1'b1;
            else
                n = realign(n);
        end
        return n;
    endfunction

    function automatic event_kind_t classify(int plen);
        if (found_kind == MOD_UNKNOWN)
        begin
            if (plen == PLEN_NEW && {kept[3], kept[4], kept[5], kept[6]} == TYPE_NEW_ID)
            begin
                found_kind = MOD_NEW;
                return EV_NEW_MODULE;
            end
            if (plen == PLEN_OLD && {kept[3], kept[4]} == TYPE_OLD_ID)
            begin
                found_kind = MOD_OLD;
                return EV_OLD_MODULE;
            end
            return EV_OTHER;
        end
        if (plen == PLEN_CARD && kept[3] == reply_cmd)
        begin
            card_before = card_now;
            card_now = {kept[4], kept[5], kept[6], kept[7]};
            return EV_CARD_READ;
        end
        return EV_OTHER;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        int           n;
        int           len;
        int           i;
        logic [7:0]   x;
        frame_event_t ev;
        n = kept_count;
        if (n == 0)
        begin
            if (b == HDR0)
            begin
                kept[0] = b;
                kept_count = 1;
            end
        end
        else if (n == 1)
        begin
            kept[1] = b;
            kept_count = (b == HDR1) ? 2 : realign(2);
        end
        else if (n == 2)
        begin
            kept[2] = b;
            kept_count = drop_stale(3);
        end
        else
        begin
            len = kept[2];
            if (!length_fits(len) || n > len + 2)
                kept_count = 0;
            else
            begin
                kept[n] = b;
                if (n <= len + 1)
                    kept_count = n + 1;
                else
                begin
                    x = 8'h00;
                    for (i = 2; i <= len + 1; i++)
                        x ^= kept[i];
                    if (x != b)
                        kept_count = drop_stale(len + 3);
                    else
                    begin
                        kept_count = 0;
                        ev.kind = classify(len - 1);
                        ev.card = card_now;
                        ev.prev_card = card_before;
                        ev.mtype = found_kind;
                        ev.plen = 8'(len - 1);
                        expected_events.push_back(ev);
                    end
                end
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_byte(s_axis_tdata);
            bytes_sent++;
        end
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= 8'($urandom);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        frame_event_t ev;
        if (m_axis_tvalid && m_axis_tready)
        begin
            events_seen++;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event, tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                ev = expected_events.pop_front();
                if (m_axis_tdata[1:0] != ev.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", ev.kind, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[33:2] != ev.card)
                begin
                    $error("card_id: expected %h, got %h", ev.card, m_axis_tdata[33:2]);
                    error_count++;
                end
                if (m_axis_tdata[65:34] != ev.prev_card)
                begin
                    $error("previous_card_id: expected %h, got %h",
                           ev.prev_card, m_axis_tdata[65:34]);
                    error_count++;
                end
                if (m_axis_tdata[67:66] != ev.mtype)
                begin
                    $error("module_type: expected %0d, got %0d", ev.mtype, m_axis_tdata[67:66]);
                    error_count++;
                end
                if (m_axis_tdata[75:68] != ev.plen)
                begin
                    $error("payload_length: expected %0d, got %0d",
                           ev.plen, m_axis_tdata[75:68]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return HDR0;
            1:       return HDR1;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // damage: 0 intact, 1 one byte flipped, 2 cut short
    task automatic add_frame(input int plen, input int damage);
        logic [7:0] fr [0:31];
        logic [7:0] chk;
        int         flen;
        int         k;
        int         pos;
        fr[0] = HDR0;
        fr[1] = HDR1;
        fr[2] = 8'(plen + 1);
        chk = fr[2];
        for (k = 0; k < plen; k++)
        begin
            fr[3+k] = body_bytes[k];
            chk ^= body_bytes[k];
        end
        fr[plen+3] = chk;
        flen = plen + 4;
        if (damage == 1)
        begin
            pos = $urandom_range(flen - 1);
            fr[pos] ^= 8'($urandom_range(255, 1));
        end
        else if (damage == 2)
            flen = $urandom_range(flen - 1, 1);
        for (k = 0; k < flen; k++)
            push_byte(fr[k]);
    endtask

    task automatic load_card(input logic [7:0] cmd);
        int k;
        body_bytes[0] = cmd;
        for (k = 1; k <= 4; k++)
            body_bytes[k] = 8'($urandom);
        if ($urandom_range(9) == 0)
            for (k = 1; k <= 4; k++)
                body_bytes[k] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endtask

    task automatic load_random(output int plen);
        int k;
        plen = ($urandom_range(19) == 0) ? $urandom_range(28) : $urandom_range(6);
        for (k = 0; k < plen; k++)
            body_bytes[k] = rand_byte();
        if (plen != 0 && $urandom_range(3) == 0)
            body_bytes[0] = reply_cmd;
    endtask

    task automatic fill_random(input int target);
        int start;
        int r;
        int plen;
        int k;
        start = bytes_queued;
        while (bytes_queued - start < target)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                load_card(reply_cmd);
                add_frame(PLEN_CARD, 0);
            end
            else if (r < 60)
            begin
                load_random(plen);
                add_frame(plen, 0);
            end
            else if (r < 68)
            begin
                if ($urandom_range(1) != 0)
                begin
                    {body_bytes[0], body_bytes[1], body_bytes[2], body_bytes[3]} = TYPE_NEW_ID;
                    add_frame(PLEN_NEW, 0);
                end
                else
                begin
                    {body_bytes[0], body_bytes[1]} = TYPE_OLD_ID;
                    add_frame(PLEN_OLD, 0);
                end
            end
            else if (r < 76)
            begin
                load_card(reply_cmd);
                case ($urandom_range(2))
                    0: add_frame(PLEN_CARD - 1, 0);
                    1:
                    begin
                        body_bytes[5] = 8'($urandom);
                        add_frame(PLEN_CARD + 1, 0);
                    end
                    default:
                    begin
                        body_bytes[0] ^= 8'($urandom_range(255, 1));
                        add_frame(PLEN_CARD, 0);
                    end
                endcase
            end
            else if (r < 92)
            begin
                if ($urandom_range(1) != 0)
                begin
                    load_card(reply_cmd);
                    plen = PLEN_CARD;
                end
                else
                    load_random(plen);
                add_frame(plen, $urandom_range(2, 1));
            end
            else
            begin
                plen = $urandom_range(6, 1);
                for (k = 0; k < plen; k++)
                    push_byte(($urandom_range(3) == 0) ? 8'h00 : rand_byte());
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reply_cmd(input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reply_cmd = v;
        settings_used++;
    endtask

    initial
    begin
        logic [7:0] cmd_list [0:5];
        int         ph;
        cmd_list[0] = 8'hFF;
        cmd_list[1] = 8'h00;
        cmd_list[2] = HDR0;
        cmd_list[3] = 8'($urandom);
        cmd_list[4] = CMD_RESET;
        cmd_list[5] = 8'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // junk, AA then AA, bad length zero, length too long, empty payload, then a module type frame and a card read
        push_byte(8'hFF);
        push_byte(HDR0);
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(8'h00);
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(8'(FRAME_MAX - 2));
        add_frame(0, 0);
        if ($urandom_range(1) != 0)
        begin
            {body_bytes[0], body_bytes[1], body_bytes[2], body_bytes[3]} = TYPE_NEW_ID;
            add_frame(PLEN_NEW, 0);
        end
        else
        begin
            {body_bytes[0], body_bytes[1]} = TYPE_OLD_ID;
            add_frame(PLEN_OLD, 0);
        end
        body_bytes[0] = CMD_RESET;
        {body_bytes[1], body_bytes[2], body_bytes[3], body_bytes[4]} = 32'hFFFF_FFFF;
        add_frame(PLEN_CARD, 0);
        wait_quiet();

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
            begin
                src_idle = 17;
                snk_idle = 54;
            end
            else if (ph < 4)
            begin
                src_idle = 54;
                snk_idle = 17;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            write_reply_cmd(cmd_list[ph]);
            fill_random(305);
            wait_quiet();
        end

        $display("%0d bytes transferred, %0d events checked, %0d card command settings",
                 bytes_sent, events_seen, settings_used);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d events outstanding", expected_events.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
